// ===== hdl/smfp_pkg.sv =====
// shared types, codes and per-byte helper functions of the midi file event parser
// no dependencies; used by smfp_step and midi_file_event_parser
`default_nettype none

package smfp_pkg;

   // chunk ids, big-endian ascii
   localparam logic [31:0] ID_HEADER = 32'h4D54_6864;
   localparam logic [31:0] ID_TRACK  = 32'h4D54_726B;

   // fixed header word bytes
   localparam logic [2:0] HDR_ID_BYTES   = 3'd4;
   localparam logic [2:0] HDR_WORD_BYTES = 3'd6;
   localparam logic [31:0] HDR_WORD_LEN  = 32'd6;

   // status high nibbles and the meta status
   localparam logic [3:0] STS_NOTE_OFF  = 4'h8;
   localparam logic [3:0] STS_NOTE_ON   = 4'h9;
   localparam logic [3:0] STS_POLY_AT   = 4'hA;
   localparam logic [3:0] STS_CONTROL   = 4'hB;
   localparam logic [3:0] STS_PROGRAM   = 4'hC;
   localparam logic [3:0] STS_CHAN_AT   = 4'hD;
   localparam logic [3:0] STS_PITCH    = 4'hE;
   localparam logic [7:0] STS_META      = 8'hFF;

   // packed result width on the stream, whole bytes
   localparam int RSP_TDATA_W = 152;

   // error codes
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_HEADER = 2'd1;
   localparam logic [1:0] ERR_TRACK  = 2'd2;

   // parser phase, one-hot
   typedef enum logic [14:0] {
      PH_HID    = 15'h0001,
      PH_HLEN   = 15'h0002,
      PH_HFLD   = 15'h0004,
      PH_HSKIP  = 15'h0008,
      PH_TID    = 15'h0010,
      PH_TLEN   = 15'h0020,
      PH_DELTA  = 15'h0040,
      PH_STATUS = 15'h0080,
      PH_DATA1  = 15'h0100,
      PH_DATA2  = 15'h0200,
      PH_MTYPE  = 15'h0400,
      PH_MLEN   = 15'h0800,
      PH_MDATA  = 15'h1000,
      PH_DONE   = 15'h2000,
      PH_DEAD   = 15'h4000
   } phase_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_HEADER     = 3'd0,
      KIND_CHANNEL    = 3'd1,
      KIND_META_START = 3'd2,
      KIND_META_DATA  = 3'd3,
      KIND_ERROR      = 3'd4
   } kind_type;

   // how many data bytes follow a status
   typedef enum logic [1:0] {
      CLS_NONE = 2'd0,
      CLS_ONE  = 2'd1,
      CLS_TWO  = 2'd2,
      CLS_META = 2'd3
   } class_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  field_count;
      logic [31:0] shift_accum;
      logic [31:0] track_time;
      logic [7:0]  running_status;
      logic [7:0]  current_status;
      logic [7:0]  first_data;
      logic [31:0] track_bytes_left;
      logic [15:0] tracks_total;
      logic [15:0] track_number;
      logic [31:0] meta_bytes_left;
      logic [47:0] header_words;
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] event_time;
      logic [7:0]  status;
      logic [15:0] value_a;
      logic [15:0] value_b;
      logic [15:0] value_c;
      logic [31:0] meta_length;
      logic [7:0]  data_byte;
      logic        last_data;
      logic [15:0] track_index;
      logic [1:0]  error_code;
   } rsp_type;

   localparam state_type RESET_STATE = '{
      phase:            PH_HID,
      field_count:      3'd0,
      shift_accum:      32'd0,
      track_time:       32'd0,
      running_status:   8'd0,
      current_status:   8'd0,
      first_data:       8'd0,
      track_bytes_left: 32'd0,
      tracks_total:     16'd0,
      track_number:     16'd0,
      meta_bytes_left:  32'd0,
      header_words:     48'd0
   };

   localparam rsp_type RSP_IDLE = '{
      kind:        KIND_HEADER,
      event_time:  32'd0,
      status:      8'd0,
      value_a:     16'd0,
      value_b:     16'd0,
      value_c:     16'd0,
      meta_length: 32'd0,
      data_byte:   8'd0,
      last_data:   1'b0,
      track_index: 16'd0,
      error_code:  ERR_NONE
   };

   // data byte count class of a status byte
   function automatic class_type f_class(logic [7:0] sts);
      class_type c;
      case (sts[7:4]) inside
         STS_NOTE_OFF, STS_NOTE_ON, STS_POLY_AT, STS_CONTROL, STS_PITCH: c = CLS_TWO;
         STS_PROGRAM, STS_CHAN_AT: c = CLS_ONE;
         default: c = (sts == STS_META) ? CLS_META : CLS_NONE;
      endcase
      return c;
   endfunction

   // one track byte used up, floored at zero
   function automatic state_type f_take(state_type s);
      state_type r;
      r = s;
      if (r.track_bytes_left != 32'd0) begin
         r.track_bytes_left = r.track_bytes_left - 32'd1;
      end
      return r;
   endfunction

   // end of event: next delta, next track or done
   function automatic state_type f_boundary(state_type s);
      state_type r;
      r = s;
      r.shift_accum = 32'd0;
      r.field_count = 3'd0;
      if (r.track_bytes_left != 32'd0) begin
         r.phase = PH_DELTA;
      end else begin
         r.track_number = r.track_number + 16'd1;
         r.phase = (r.track_number >= r.tracks_total) ? PH_DONE : PH_TID;
      end
      return r;
   endfunction

   // header finished, go to the first track, or to done when no tracks are announced
   function automatic state_type f_after_header(state_type s);
      state_type r;
      r = s;
      r.track_number = 16'd0;
      r.field_count = 3'd0;
      r.shift_accum = 32'd0;
      r.phase = (r.tracks_total == 16'd0) ? PH_DONE : PH_TID;
      return r;
   endfunction

   // one byte of a variable-length delta
   function automatic state_type f_delta(state_type s, logic [7:0] in_byte);
      state_type r;
      r = f_take(s);
      r.shift_accum = {s.shift_accum[24:0], in_byte[6:0]};
      if (!in_byte[7]) begin
         r.track_time = r.track_time + r.shift_accum;
         r.shift_accum = 32'd0;
         r.phase = PH_STATUS;
      end
      return r;
   endfunction

   // track event result from the current state
   function automatic rsp_type f_event(state_type s, kind_type kind, logic [7:0] a,
                                       logic [7:0] b);
      rsp_type r;
      r = RSP_IDLE;
      r.kind = kind;
      r.event_time = s.track_time;
      r.status = s.current_status;
      r.value_a = {8'h00, a};
      r.value_b = {8'h00, b};
      r.track_index = s.track_number;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/smfp_step.sv =====
// next parser state and optional result for one file byte
// depends on smfp_pkg
`default_nettype none

module smfp_step (
   input  wire smfp_pkg::state_type state_ff,
   input  wire logic [7:0]          in_byte,
   input  wire logic                file_start,
   output smfp_pkg::state_type      state_in,
   output smfp_pkg::rsp_type        rsp_in,
   output logic                     has_result
);
   import smfp_pkg::*;

   state_type s;
   state_type n;
   rsp_type   r;
   class_type run_cls;
   class_type cur_cls;
   logic      hit;

   always_comb begin
      // restart on a new file, then fold a running status data byte into its phase
      s = file_start ? RESET_STATE : state_ff;
      run_cls = f_class(s.running_status);
      cur_cls = f_class(s.current_status);
      if (s.phase == PH_STATUS && !in_byte[7] && run_cls != CLS_NONE) begin
         s.current_status = s.running_status;
         s.phase = (run_cls == CLS_META) ? PH_MTYPE : PH_DATA1;
         cur_cls = run_cls;
      end

      n = s;
      r = RSP_IDLE;
      hit = 1'b0;

      unique case (s.phase)
         // chunk ids
         PH_HID, PH_TID: begin
            n.shift_accum = {s.shift_accum[23:0], in_byte};
            n.field_count = s.field_count + 3'd1;
            if (n.field_count >= HDR_ID_BYTES) begin
               n.field_count = 3'd0;
               if (s.phase == PH_HID) begin
                  if (n.shift_accum != ID_HEADER) begin
                     r.kind = KIND_ERROR;
                     r.track_index = s.track_number;
                     r.error_code = ERR_HEADER;
                     hit = 1'b1;
                     n.phase = PH_DEAD;
                  end else begin
                     n.phase = PH_HLEN;
                     n.shift_accum = 32'd0;
                  end
               end else begin
                  if (n.shift_accum != ID_TRACK) begin
                     r.kind = KIND_ERROR;
                     r.track_index = s.track_number;
                     r.error_code = ERR_TRACK;
                     hit = 1'b1;
                     n.phase = PH_DEAD;
                  end else begin
                     n.track_time = 32'd0;
                     n.running_status = 8'd0;
                     n.phase = PH_TLEN;
                     n.shift_accum = 32'd0;
                  end
               end
            end
         end
         // header length
         PH_HLEN: begin
            n.shift_accum = {s.shift_accum[23:0], in_byte};
            n.field_count = s.field_count + 3'd1;
            if (n.field_count == HDR_ID_BYTES) begin
               n.field_count = 3'd0;
               n.phase = PH_HFLD;
            end
         end
         // format, track count, timebase
         PH_HFLD: begin
            n.header_words = {s.header_words[39:0], in_byte};
            n.field_count = s.field_count + 3'd1;
            if (n.field_count >= HDR_WORD_BYTES) begin
               n.tracks_total = n.header_words[31:16];
               r.kind = KIND_HEADER;
               r.value_a = n.header_words[47:32];
               r.value_b = n.header_words[31:16];
               r.value_c = n.header_words[15:0];
               hit = 1'b1;
               if (s.shift_accum > HDR_WORD_LEN) begin
                  n.shift_accum = s.shift_accum - HDR_WORD_LEN;
                  n.phase = PH_HSKIP;
               end else begin
                  n = f_after_header(n);
               end
            end
         end
         // surplus header bytes
         PH_HSKIP: begin
            n.shift_accum = s.shift_accum - 32'd1;
            if (n.shift_accum == 32'd0) begin
               n = f_after_header(n);
            end
         end
         // track length
         PH_TLEN: begin
            n.shift_accum = {s.shift_accum[23:0], in_byte};
            n.field_count = s.field_count + 3'd1;
            if (n.field_count == HDR_ID_BYTES) begin
               n.track_bytes_left = n.shift_accum;
               n = f_boundary(n);
            end
         end
         PH_DELTA: begin
            n = f_delta(s, in_byte);
         end
         // status byte, or a data byte under a status that takes none
         PH_STATUS: begin
            if (in_byte[7]) begin
               n = f_take(s);
               n.running_status = in_byte;
               n.current_status = in_byte;
               case (f_class(in_byte))
                  CLS_META: n.phase = PH_MTYPE;
                  CLS_NONE: begin
                     r = f_event(n, KIND_CHANNEL, 8'h00, 8'h00);
                     hit = 1'b1;
                     n = f_boundary(n);
                  end
                  default: n.phase = PH_DATA1;
               endcase
            end else begin
               n.current_status = s.running_status;
               r = f_event(n, KIND_CHANNEL, 8'h00, 8'h00);
               hit = 1'b1;
               n = f_boundary(n);
               // the same byte then opens the next event
               if (n.phase == PH_DELTA) begin
                  n = f_delta(n, in_byte);
               end else if (n.phase == PH_TID) begin
                  n.shift_accum = {n.shift_accum[23:0], in_byte};
                  n.field_count = n.field_count + 3'd1;
               end
            end
         end
         PH_DATA1: begin
            n = f_take(s);
            if (cur_cls == CLS_TWO) begin
               n.first_data = in_byte;
               n.phase = PH_DATA2;
            end else begin
               r = f_event(n, KIND_CHANNEL, in_byte, 8'h00);
               hit = 1'b1;
               n = f_boundary(n);
            end
         end
         PH_DATA2: begin
            n = f_take(s);
            r = f_event(n, KIND_CHANNEL, s.first_data, in_byte);
            hit = 1'b1;
            n = f_boundary(n);
         end
         PH_MTYPE: begin
            n = f_take(s);
            n.first_data = in_byte;
            n.shift_accum = 32'd0;
            n.phase = PH_MLEN;
         end
         // meta length, variable length
         PH_MLEN: begin
            n = f_take(s);
            n.shift_accum = {s.shift_accum[24:0], in_byte[6:0]};
            if (!in_byte[7]) begin
               n.meta_bytes_left = n.shift_accum;
               r = f_event(n, KIND_META_START, s.first_data, 8'h00);
               r.meta_length = n.shift_accum;
               r.last_data = (n.shift_accum == 32'd0);
               hit = 1'b1;
               if (n.shift_accum == 32'd0) begin
                  n = f_boundary(n);
               end else begin
                  n.phase = PH_MDATA;
               end
            end
         end
         PH_MDATA: begin
            n = f_take(s);
            n.meta_bytes_left = s.meta_bytes_left - 32'd1;
            r = f_event(n, KIND_META_DATA, s.first_data, 8'h00);
            r.meta_length = s.shift_accum;
            r.data_byte = in_byte;
            r.last_data = (n.meta_bytes_left == 32'd0);
            hit = 1'b1;
            if (n.meta_bytes_left == 32'd0) begin
               n = f_boundary(n);
            end
         end
         PH_DONE, PH_DEAD: begin
            n = s;
         end
         default: begin
            n = s;
         end
      endcase

      state_in = n;
      rsp_in = r;
      has_result = hit;
   end

endmodule

`default_nettype wire

// ===== hdl/midi_file_event_parser.sv =====
// standard midi file event parser: input register, per-byte step logic, result register
// depends on smfp_pkg and smfp_step
// an accepted byte is registered, then its result is registered and shown on rsp_tvalid
// throughput: one byte per cycle while results are not stalled; state updates once per byte
// reset: synchronous, active high; clears both stage valids and the parser state,
// and a beat with file_start set restarts the parser before its byte is taken in
`default_nettype none

module midi_file_event_parser (
   input  wire logic         clock,
   input  wire logic         reset,
   // in_byte [7:0]
   input  wire logic [7:0]   req_tdata,
   // file_start [0]
   input  wire logic [0:0]   req_tuser,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // event_time [31:0], status [39:32], value_a [55:40], value_b [71:56],
   // value_c [87:72], meta_length [119:88], data_byte [127:120],
   // track_index [143:128], error_code [145:144], zero fill [151:146]
   output logic [smfp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // kind [2:0]
   output logic [2:0]        rsp_tuser,
   // last_data
   output logic              rsp_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready
);
   import smfp_pkg::*;

   logic       req_valid_ff;
   logic [7:0] req_byte_ff;
   logic       req_start_ff;

   state_type  state_ff;
   state_type  state_in;
   rsp_type    rsp_in;
   rsp_type    rsp_ff;
   logic       rsp_valid_ff;
   logic       has_result;
   logic       out_free;
   logic       adv;

   // handshake: a byte advances when it yields no result or the result register can take it
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign adv        = req_valid_ff && (out_free || !has_result);
   assign req_tready = !reset && (!req_valid_ff || adv);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         req_byte_ff  <= req_tdata;
         req_start_ff <= req_tuser[0];
      end
   end

   // per-byte parser logic
   smfp_step u_step (
      .state_ff   (state_ff),
      .in_byte    (req_byte_ff),
      .file_start (req_start_ff),
      .state_in   (state_in),
      .rsp_in     (rsp_in),
      .has_result (has_result)
   );

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RESET_STATE;
      end else if (adv) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (adv && has_result) begin
         rsp_ff <= rsp_in;
      end
   end

   // result beat packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_ff.error_code, rsp_ff.track_index, rsp_ff.data_byte,
                        rsp_ff.meta_length, rsp_ff.value_c, rsp_ff.value_b, rsp_ff.value_a,
                        rsp_ff.status, rsp_ff.event_time};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last_data;

   // a pending result is never overwritten by a new one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(adv && has_result))
      else $error("result register overwritten while stalled");

   // a loaded result is presented next cycle
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      (adv && has_result) |=> rsp_valid_ff)
      else $error("loaded result not presented");

   // after an error only a new file produces results
   a_dead_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && state_ff.phase == PH_DEAD && !req_start_ff) |-> !has_result)
      else $error("result produced after error");

   // error results carry a code
   a_error_coded: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_ERROR) |-> (rsp_ff.error_code != ERR_NONE))
      else $error("error result without code");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// self-checking testbench for midi_file_event_parser: drives standard midi file byte streams,
// predicts every result from its own model of the parser and checks each result beat
// depends on smfp_pkg (types, codes) and the midi_file_event_parser rtl

module tb;
   import smfp_pkg::*;

   localparam int unsigned RANDOM_BEATS = 1500;
   localparam int unsigned PHASE_BEATS  = 150;
   localparam int unsigned DRAIN_EVERY  = 300;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned TAIL_CYCLES  = 20;
   localparam int unsigned LEN_BYTES    = 4;
   localparam int unsigned META_RUN     = 3;
   localparam logic [3:0]  SYS_NIBBLE   = 4'hF;

   typedef struct packed {
      logic       first;
      logic [7:0] data;
   } in_beat_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic [7:0]   req_tdata  = 8'd0;
   logic [0:0]   req_tuser  = 1'b0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [151:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;

   // parser model state
   phase_type   ph;
   int unsigned fcount;
   logic [31:0] accum;
   logic [31:0] tick;
   logic [7:0]  run_sts;
   logic [7:0]  cur_sts;
   logic [7:0]  held_data;
   logic [31:0] tbleft;
   logic [15:0] trk_total;
   logic [15:0] trk_num;
   logic [31:0] mleft;
   logic [47:0] hdr_bits;
   bit          again_byte;

   // stimulus and checking
   in_beat_type byte_feed[$];
   rsp_type     events_due[$];
   logic [7:0]  frame[$];
   logic [7:0]  track_body[$];
   bit          file_cut;
   bit          drain_wait;
   int unsigned gap_pct;
   int unsigned stall_pct;
   int unsigned beats_sent;
   int unsigned files_made;
   int unsigned results_seen;
   int unsigned kinds_seen[5];
   int unsigned mismatch_count;
   int unsigned cycle_count;

   // one short track using every kind of event, running status with no data included
   logic [7:0] demo_track [20] = '{
      8'h00, 8'h7F, 8'h90, 8'h3C, 8'h7F, 8'h00, 8'h3E, 8'h40, 8'h81, 8'h80,
      8'h00, 8'hC5, 8'h10, 8'h00, 8'hF8, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h41
   };

   midi_file_event_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- parser model

   function automatic void clear_parser();
      ph        = PH_HID;
      fcount    = 0;
      accum     = '0;
      tick      = '0;
      run_sts   = '0;
      cur_sts   = '0;
      held_data = '0;
      tbleft    = '0;
      trk_total = '0;
      trk_num   = '0;
      mleft     = '0;
      hdr_bits  = '0;
   endfunction

   // number of data bytes a status calls for
   function automatic class_type status_class(logic [7:0] s);
      if (s == STS_META)
         return CLS_META;
      if (s[7:4] == STS_PROGRAM || s[7:4] == STS_CHAN_AT)
         return CLS_ONE;
      if (s[7] && s[7:4] != SYS_NIBBLE)
         return CLS_TWO;
      return CLS_NONE;
   endfunction

   function automatic void use_track_byte();
      if (tbleft != 0)
         tbleft = tbleft - 32'd1;
   endfunction

   // event done: next delta, next track, or nothing more to parse
   function automatic void end_event();
      accum  = '0;
      fcount = 0;
      if (tbleft != 0) begin
         ph = PH_DELTA;
      end else begin
         trk_num = trk_num + 16'd1;
         ph = (trk_num >= trk_total) ? PH_DONE : PH_TID;
      end
   endfunction

   function automatic void enter_tracks();
      trk_num = '0;
      fcount  = 0;
      accum   = '0;
      ph = (trk_total == 16'd0) ? PH_DONE : PH_TID;
   endfunction

   function automatic rsp_type chunk_error(logic [1:0] code);
      rsp_type r;
      r = RSP_IDLE;
      r.kind        = KIND_ERROR;
      r.track_index = trk_num;
      r.error_code  = code;
      ph = PH_DEAD;
      return r;
   endfunction

   function automatic rsp_type track_beat(kind_type k, logic [7:0] a, logic [7:0] b);
      rsp_type r;
      r = RSP_IDLE;
      r.kind        = k;
      r.event_time  = tick;
      r.status      = cur_sts;
      r.value_a     = {8'h00, a};
      r.value_b     = {8'h00, b};
      r.track_index = trk_num;
      return r;
   endfunction

   // one byte through the parser; returns 1 when it yields a result
   function automatic bit feed_byte(logic [7:0] b, output rsp_type r);
      bit        got;
      bit        retry;
      class_type k;
      r   = RSP_IDLE;
      got = 1'b0;
      do begin
         retry = 1'b0;
         case (ph)
            PH_HID, PH_TID: begin
               accum = {accum[23:0], b};
               fcount++;
               if (fcount == 32'(HDR_ID_BYTES)) begin
                  fcount = 0;
                  if (ph == PH_HID) begin
                     if (accum != ID_HEADER) begin
                        r = chunk_error(ERR_HEADER);
                        got = 1'b1;
                     end else begin
                        ph = PH_HLEN;
                        accum = '0;
                     end
                  end else if (accum != ID_TRACK) begin
                     r = chunk_error(ERR_TRACK);
                     got = 1'b1;
                  end else begin
                     tick    = '0;
                     run_sts = '0;
                     ph      = PH_TLEN;
                     accum   = '0;
                  end
               end
            end
            PH_HLEN: begin
               accum = {accum[23:0], b};
               fcount++;
               if (fcount == LEN_BYTES) begin
                  fcount = 0;
                  ph = PH_HFLD;
               end
            end
            PH_HFLD: begin
               hdr_bits = {hdr_bits[39:0], b};
               fcount++;
               if (fcount == 32'(HDR_WORD_BYTES)) begin
                  trk_total = hdr_bits[31:16];
                  r.kind    = KIND_HEADER;
                  r.value_a = hdr_bits[47:32];
                  r.value_b = hdr_bits[31:16];
                  r.value_c = hdr_bits[15:0];
                  got = 1'b1;
                  if (accum > HDR_WORD_LEN) begin
                     accum = accum - HDR_WORD_LEN;
                     ph = PH_HSKIP;
                  end else begin
                     enter_tracks();
                  end
               end
            end
            PH_HSKIP: begin
               accum = accum - 32'd1;
               if (accum == 0)
                  enter_tracks();
            end
            PH_TLEN: begin
               accum = {accum[23:0], b};
               fcount++;
               if (fcount == LEN_BYTES) begin
                  tbleft = accum;
                  end_event();
               end
            end
            PH_DELTA: begin
               use_track_byte();
               accum = {accum[24:0], b[6:0]};
               if (!b[7]) begin
                  tick  = tick + accum;
                  accum = '0;
                  ph    = PH_STATUS;
               end
            end
            PH_STATUS: begin
               if (b[7]) begin
                  use_track_byte();
                  run_sts = b;
                  cur_sts = b;
                  k = status_class(b);
                  if (k == CLS_META) begin
                     ph = PH_MTYPE;
                  end else if (k != CLS_NONE) begin
                     ph = PH_DATA1;
                  end else begin
                     r = track_beat(KIND_CHANNEL, 8'd0, 8'd0);
                     got = 1'b1;
                     end_event();
                  end
               end else begin
                  // running status: the data byte is taken again by the next phase
                  cur_sts = run_sts;
                  k = status_class(cur_sts);
                  if (k == CLS_NONE) begin
                     r = track_beat(KIND_CHANNEL, 8'd0, 8'd0);
                     got = 1'b1;
                     end_event();
                     again_byte = 1'b1;
                  end else begin
                     ph = (k == CLS_META) ? PH_MTYPE : PH_DATA1;
                     retry = 1'b1;
                  end
               end
            end
            PH_DATA1: begin
               use_track_byte();
               if (status_class(cur_sts) == CLS_TWO) begin
                  held_data = b;
                  ph = PH_DATA2;
               end else begin
                  r = track_beat(KIND_CHANNEL, b, 8'd0);
                  got = 1'b1;
                  end_event();
               end
            end
            PH_DATA2: begin
               use_track_byte();
               r = track_beat(KIND_CHANNEL, held_data, b);
               got = 1'b1;
               end_event();
            end
            PH_MTYPE: begin
               use_track_byte();
               held_data = b;
               accum = '0;
               ph = PH_MLEN;
            end
            PH_MLEN: begin
               use_track_byte();
               accum = {accum[24:0], b[6:0]};
               if (!b[7]) begin
                  mleft = accum;
                  r = track_beat(KIND_META_START, held_data, 8'd0);
                  r.meta_length = accum;
                  r.last_data   = (accum == 0);
                  got = 1'b1;
                  if (accum == 0)
                     end_event();
                  else
                     ph = PH_MDATA;
               end
            end
            PH_MDATA: begin
               use_track_byte();
               mleft = mleft - 32'd1;
               r = track_beat(KIND_META_DATA, held_data, 8'd0);
               r.meta_length = accum;
               r.data_byte   = b;
               r.last_data   = (mleft == 0);
               got = 1'b1;
               if (mleft == 0)
                  end_event();
            end
            default: begin
            end
         endcase
      end while (retry);
      return got;
   endfunction

   // accepted byte beat: restart on file start, queue the result it causes
   function automatic void predict_beat(logic [7:0] b, logic first);
      rsp_type ev;
      rsp_type dropped;
      if (first)
         clear_parser();
      again_byte = 1'b0;
      if (feed_byte(b, ev))
         events_due.push_back(ev);
      if (again_byte) begin
         again_byte = 1'b0;
         void'(feed_byte(b, dropped));
      end
   endfunction

   // ---------------------------------------------------------------- file builders

   function automatic void put_be(logic [31:0] v, int n);
      for (int i = n - 1; i >= 0; i--)
         frame.push_back(v[8*i +: 8]);
   endfunction

   function automatic void put_body(logic [7:0] b);
      track_body.push_back(b);
   endfunction

   // mostly proper data bytes, now and then one with the top bit set
   function automatic logic [7:0] data_val();
      return ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(127));
   endfunction

   // variable-length delta, sometimes long enough to wrap
   function automatic void put_delta();
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(19);
      n = (pick < 15) ? 1 : (pick < 18) ? 2 : (pick == 18) ? $urandom_range(3, 4)
                                                         : $urandom_range(5, 6);
      repeat (n - 1) put_body({1'b1, 7'($urandom_range(127))});
      put_body(8'($urandom_range(127)));
   endfunction

   // meta type, length and data; a huge length cuts the file short
   function automatic void add_meta_tail();
      int unsigned len;
      put_body(8'($urandom_range(255)));
      if ($urandom_range(39) == 0) begin
         repeat (4) put_body({1'b1, 7'($urandom_range(127))});
         put_body(8'($urandom_range(127)));
         repeat (2) put_body(8'($urandom_range(255)));
         file_cut = 1'b1;
      end else begin
         case ($urandom_range(9))
            0, 1: len = 0;
            9: len = $urandom_range(128, 200);
            default: len = $urandom_range(1, 6);
         endcase
         if ($urandom_range(7) == 0)
            put_body(8'h80);
         if (len > 127)
            put_body({1'b1, 7'(len >> 7)});
         put_body({1'b0, 7'(len)});
         repeat (len) put_body(8'($urandom_range(255)));
      end
   endfunction

   function automatic void add_events(int unsigned count);
      int unsigned run_len;
      bit          skip_delta;
      logic [7:0]  sts;
      run_len    = 0;
      skip_delta = 1'b0;
      for (int unsigned e = 0; e < count && !file_cut; e++) begin
         if (!skip_delta)
            put_delta();
         skip_delta = 1'b0;
         case ($urandom_range(9))
            0, 1, 2: begin
               sts[7:4] = STS_NOTE_ON;
               sts[3:0] = 4'($urandom_range(15));
               case ($urandom_range(4))
                  0: sts[7:4] = STS_NOTE_OFF;
                  1: sts[7:4] = STS_POLY_AT;
                  2: sts[7:4] = STS_CONTROL;
                  3: sts[7:4] = STS_PITCH;
                  default: begin
                  end
               endcase
               put_body(sts);
               put_body(data_val());
               put_body(data_val());
               run_len = 2;
            end
            3: begin
               sts[7:4] = $urandom_range(1) ? STS_PROGRAM : STS_CHAN_AT;
               sts[3:0] = 4'($urandom_range(15));
               put_body(sts);
               put_body(data_val());
               run_len = 1;
            end
            4, 5: begin
               // running status; with no data status the byte doubles as the next delta
               case (run_len)
                  0: begin
                     put_body(8'($urandom_range(127)));
                     skip_delta = 1'b1;
                  end
                  1: put_body(data_val());
                  2: begin
                     put_body(data_val());
                     put_body(data_val());
                  end
                  default: add_meta_tail();
               endcase
            end
            6: begin
               put_body(8'($urandom_range(8'hFE, 8'hF0)));
               run_len = 0;
            end
            default: begin
               put_body(STS_META);
               add_meta_tail();
               run_len = META_RUN;
            end
         endcase
      end
   endfunction

   function automatic void add_track();
      logic [31:0] len;
      logic [31:0] id;
      track_body.delete();
      add_events($urandom_range(1, 8));
      len = 32'(track_body.size());
      case ($urandom_range(19))
         0: begin
            track_body.delete();
            len = 0;
            file_cut = 1'b0;
         end
         1, 2: len = len + $urandom_range(1, 3);
         3: if (len > 3) len = len - $urandom_range(1, 3);
         default: begin
         end
      endcase
      id = ($urandom_range(19) == 0) ? (ID_TRACK ^ (32'd1 << $urandom_range(31))) : ID_TRACK;
      put_be(id, 4);
      put_be(len, 4);
      foreach (track_body[i])
         frame.push_back(track_body[i]);
   endfunction

   function automatic void commit_file();
      foreach (frame[i])
         byte_feed.push_back('{first: (i == 0), data: frame[i]});
      frame.delete();
      files_made++;
   endfunction

   function automatic void add_file();
      logic [31:0] hlen;
      logic [15:0] ntrk;
      int unsigned built;
      file_cut = 1'b0;
      put_be(($urandom_range(19) == 0) ? (ID_HEADER ^ (32'd1 << $urandom_range(31)))
                                       : ID_HEADER, 4);
      case ($urandom_range(9))
         0: hlen = $urandom_range(5);
         1: hlen = $urandom_range(7, 10);
         default: hlen = HDR_WORD_LEN;
      endcase
      put_be(hlen, 4);
      put_be(($urandom_range(4) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(2), 2);
      case ($urandom_range(9))
         0: ntrk = 16'd0;
         1, 2, 3, 4: ntrk = 16'd1;
         5, 6, 7: ntrk = 16'd2;
         8: ntrk = 16'd3;
         default: ntrk = 16'($urandom_range(16'hFFFF));
      endcase
      put_be({16'h0000, ntrk}, 2);
      put_be($urandom_range(16'hFFFF), 2);
      if (hlen > HDR_WORD_LEN)
         repeat (hlen - HDR_WORD_LEN) frame.push_back(8'($urandom_range(255)));
      built = (ntrk > 16'd3) ? $urandom_range(1, 2) : 32'(ntrk);
      for (int unsigned t = 0; t < built && !file_cut; t++)
         add_track();
      // trailing bytes after the last track; the parser ignores them once it is done
      if (!file_cut && $urandom_range(4) == 0)
         repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(255)));
      commit_file();
   endfunction

   // garbage, sometimes behind a good header id
   function automatic void add_noise();
      if ($urandom_range(1))
         put_be(ID_HEADER, 4);
      repeat ($urandom_range(1, 16)) frame.push_back(8'($urandom_range(255)));
      commit_file();
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void report_fault(string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      mismatch_count++;
   endfunction

   function automatic void check_field(string name, logic [31:0] seen, logic [31:0] want);
      if (seen !== want)
         report_fault($sformatf("%s got %0h expected %0h", name, seen, want));
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      in_beat_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'd0;
         req_tuser  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_beat(req_tdata, req_tuser[0]);
            beats_sent++;
            if (beats_sent % DRAIN_EVERY == 0)
               drain_wait = 1'b1;
            case ((beats_sent / PHASE_BEATS) % 4)
               0: begin
                  gap_pct   = 0;
                  stall_pct = 0;
               end
               1: begin
                  gap_pct   = 80;
                  stall_pct = 0;
               end
               2: begin
                  gap_pct   = 0;
                  stall_pct = 80;
               end
               default: begin
                  gap_pct   = 36;
                  stall_pct = 36;
               end
            endcase
         end
         // hold off until every result so far has come back
         if (drain_wait && events_due.size() == 0)
            drain_wait = 1'b0;
         if (!req_tvalid || req_tready) begin
            if (byte_feed.size() != 0 && !drain_wait && $urandom_range(99) >= gap_pct) begin
               nxt = byte_feed.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data;
               req_tuser  <= nxt.first;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (events_due.size() == 0) begin
               report_fault($sformatf("result of kind %0d with nothing expected", rsp_tuser));
            end else begin
               want = events_due.pop_front();
               kinds_seen[int'(want.kind)]++;
               check_field("kind",        32'(rsp_tuser),          32'(want.kind));
               check_field("event_time",  rsp_tdata[31:0],         want.event_time);
               check_field("status",      32'(rsp_tdata[39:32]),   32'(want.status));
               check_field("value_a",     32'(rsp_tdata[55:40]),   32'(want.value_a));
               check_field("value_b",     32'(rsp_tdata[71:56]),   32'(want.value_b));
               check_field("value_c",     32'(rsp_tdata[87:72]),   32'(want.value_c));
               check_field("meta_length", rsp_tdata[119:88],       want.meta_length);
               check_field("data_byte",   32'(rsp_tdata[127:120]), 32'(want.data_byte));
               check_field("track_index", 32'(rsp_tdata[143:128]), 32'(want.track_index));
               check_field("error_code",  32'(rsp_tdata[145:144]), 32'(want.error_code));
               check_field("last_data",   32'(rsp_tlast),          32'(want.last_data));
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  events_due.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus and end of run

   initial begin
      int unsigned directed_n;
      clear_parser();

      // directed: short header, two tracks announced, every event kind, then a bad track id
      put_be(ID_HEADER, 4);
      put_be(32'd0, 4);
      put_be(32'd1, 2);
      put_be(32'd2, 2);
      put_be(32'h0060, 2);
      put_be(ID_TRACK, 4);
      put_be(32'd20, 4);
      foreach (demo_track[i])
         frame.push_back(demo_track[i]);
      put_be(ID_TRACK ^ 32'd1, 4);
      commit_file();
      directed_n = byte_feed.size();

      // random files, mostly well formed, some noise
      while (byte_feed.size() < directed_n + RANDOM_BEATS) begin
         if ($urandom_range(4) == 0)
            add_noise();
         else
            add_file();
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (byte_feed.size() != 0 || req_tvalid || events_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("summary: %0d byte beats in %0d files, %0d results checked",
               beats_sent, files_made, results_seen);
      $display("summary: headers %0d, channel %0d, meta starts %0d, meta data %0d, errors %0d",
               kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3], kinds_seen[4]);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/smfp_pkg.sv
hdl/smfp_step.sv
hdl/midi_file_event_parser.sv
test/tb.sv
